FILE: sv/id3v2_text_frame_parser_top_macros.svh
// Assertion macros for the ID3v2 text frame parser.
// Used by the top level; every property is clocked on i_clk and held off in reset.
`ifndef ID3V2_TEXT_FRAME_PARSER_TOP_MACROS_SVH
`define ID3V2_TEXT_FRAME_PARSER_TOP_MACROS_SVH

// Check a condition at every clock edge out of reset
`define ID3TP_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// Check that a condition in one cycle implies another in the next cycle
`define ID3TP_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

FILE: sv/id3tp_pkg.sv
// Shared types, codes and the text frame table of the ID3v2 text frame parser.
// No dependencies; imported by the core, the result queue and the top level.
`timescale 1ns / 1ps
`default_nettype none

package id3tp_pkg;

    // Result event codes
    localparam logic [1:0] EV_TEXT = 2'd0;
    localparam logic [1:0] EV_END  = 2'd1;
    localparam logic [1:0] EV_TAG  = 2'd2;

    // Tag status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NO_TAG = 2'd1;
    localparam logic [1:0] ST_TRUNC  = 2'd2;

    // Field codes
    localparam logic [2:0] FLD_TITLE   = 3'd0;
    localparam logic [2:0] FLD_ARTIST  = 3'd1;
    localparam logic [2:0] FLD_ALBUM   = 3'd2;
    localparam logic [2:0] FLD_TRACK   = 3'd3;
    localparam logic [2:0] FLD_YEAR    = 3'd4;
    localparam logic [2:0] FLD_COMMENT = 3'd5;
    localparam logic [2:0] FLD_GENRE   = 3'd6;

    // Result slots inside one bundle, in delivery order
    localparam int SLOT_TEXT = 0;
    localparam int SLOT_END  = 1;
    localparam int SLOT_FIN  = 2;
    localparam int NUM_SLOTS = 3;

    // All results caused by one input byte
    typedef struct packed {
        logic [NUM_SLOTS-1:0] mask;
        logic [2:0]           field;
        logic [7:0]           text_byte;
        logic [1:0]           status;
    } t_bundle;

    typedef struct packed {
        logic [31:0] id;
        logic        wide;
        logic [2:0]  fld;
    } t_frame_kind;

    typedef struct packed {
        logic       hit;
        logic [2:0] fld;
    } t_frame_hit;

    localparam int NUM_FRAMES = 12;

    localparam t_frame_kind KNOWN_FRAMES [NUM_FRAMES] = '{
        '{32'h0054_5432, 1'b0, FLD_TITLE},
        '{32'h0054_5031, 1'b0, FLD_ARTIST},
        '{32'h0054_414C, 1'b0, FLD_ALBUM},
        '{32'h0054_524B, 1'b0, FLD_TRACK},
        '{32'h0054_5945, 1'b0, FLD_YEAR},
        '{32'h0043_4F4D, 1'b0, FLD_COMMENT},
        '{32'h0054_434F, 1'b0, FLD_GENRE},
        '{32'h5449_5432, 1'b1, FLD_TITLE},
        '{32'h5450_4531, 1'b1, FLD_ARTIST},
        '{32'h5441_4C42, 1'b1, FLD_ALBUM},
        '{32'h5459_4552, 1'b1, FLD_YEAR},
        '{32'h434F_4D4D, 1'b1, FLD_COMMENT}
    };

    // Match a frame ID against the text frame table for the current layout
    function automatic t_frame_hit frame_lookup(input logic [31:0] id, input logic wide);
        t_frame_hit res;
        res = '0;
        for (int i = 0; i < NUM_FRAMES; i++) begin
            if (KNOWN_FRAMES[i].id == id && KNOWN_FRAMES[i].wide == wide) begin
                res.hit = 1'b1;
                res.fld = KNOWN_FRAMES[i].fld;
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

FILE: sv/id3v2_text_frame_parser_top.sv
// Top level of the ID3v2 text frame parser: byte parser core and result queue.
// Depends on id3tp_pkg, id3tp_core, id3tp_outq and the assertion macro header.
//
//  Channel  Dir  Signals                       Contents
//  s_axis   in   tvalid tready tdata tlast     file byte, last-byte flag in tlast
//  m_axis   out  tvalid tready tdata tuser     result: event kind in tuser
//
// One file byte is taken per cycle while the queue is not full; its results pass the
// input register and are written to the result queue before they reach m_axis. A byte
// causes zero to three results, delivered one per cycle while m_axis_tready is high,
// through the single result port. A four-bundle queue absorbs bursts; s_axis stalls only when it fills.
// Reset is synchronous, active low, and clears the walk state and the queue at once.
`timescale 1ns / 1ps
`default_nettype none

`include "id3v2_text_frame_parser_top_macros.svh"

module id3v2_text_frame_parser_top #(
    parameter int TAG_LENGTH_BITS = 28
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire logic        s_axis_tlast,   // last_byte
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // [2:0] field, [10:3] text_byte, [12:11] status
    output logic [1:0]       m_axis_tuser    // [1:0] event_res
);
    import id3tp_pkg::*;

    logic       w_push;
    t_bundle    w_bundle;
    logic       w_full;
    logic [2:0] w_field;
    logic [7:0] w_text;
    logic [1:0] w_status;

    // Byte parser
    id3tp_core #(
        .TAG_LENGTH_BITS(TAG_LENGTH_BITS)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_in_byte  (s_axis_tdata),
        .i_in_last  (s_axis_tlast),
        .o_push     (w_push),
        .o_bundle   (w_bundle),
        .i_full     (w_full)
    );

    // Result queue
    id3tp_outq u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_bundle (w_bundle),
        .o_full   (w_full),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_event  (m_axis_tuser),
        .o_field  (w_field),
        .o_text   (w_text),
        .o_status (w_status)
    );

    // Pack the result fields
    assign m_axis_tdata = {3'b000, w_status, w_text, w_field};

    // Checks
    `ID3TP_ASSERT_ALWAYS(a_no_push_when_full, !(w_push && w_full), "push into a full queue")
    `ID3TP_ASSERT_ALWAYS(a_push_has_result, !w_push || (w_bundle.mask != '0), "empty bundle pushed")
    `ID3TP_ASSERT_ALWAYS(a_tag_event_clean, !(m_axis_tvalid && m_axis_tuser == EV_TAG) || (m_axis_tdata[10:0] == 11'd0), "tag event carries field text")
    `ID3TP_ASSERT_NEXT(a_full_blocks_input, w_full && !m_axis_tready, !w_push, "queue took a bundle while full and stalled")

endmodule

`default_nettype wire

FILE: sv/id3tp_core.sv
// Byte parser of the ID3v2 text frame parser: input register, tag/frame walk state
// and the bundle of results for each byte. Depends on id3tp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module id3tp_core #(
    parameter int TAG_LENGTH_BITS = 28
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic [7:0]        i_in_byte,
    input  wire logic              i_in_last,
    output logic                   o_push,
    output id3tp_pkg::t_bundle     o_bundle,
    input  wire logic              i_full
);
    import id3tp_pkg::*;

    typedef enum logic [2:0] {
        PH_HDR,
        PH_EXT,
        PH_FHDR,
        PH_PAY,
        PH_DONE
    } t_phase;

    localparam int CmpW = 34;
    localparam logic [CmpW-1:0] One = 1;
    localparam logic [CmpW-1:0] TagMax = (One << TAG_LENGTH_BITS) - One;
    localparam logic [7:0] Ver2 = 8'd2;
    localparam logic [7:0] Ver3 = 8'd3;
    localparam logic [7:0] ExtCrcMark = 8'h0A;
    localparam logic [3:0] HdrLast = 4'd9;
    localparam logic [3:0] FhdrWideLast = 4'd9;
    localparam logic [3:0] FhdrNarrowLast = 4'd5;
    localparam logic [CmpW-1:0] FhdrWideLen = 10;
    localparam logic [CmpW-1:0] FhdrNarrowLen = 6;
    localparam logic [23:0] ExtShortLen = 24'd10;
    localparam logic [23:0] ExtLongLen = 24'd14;
    localparam logic [7:0] Sig [3] = '{8'h49, 8'h44, 8'h33};

    // Input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    logic       w_go;

    // Walk state and next values
    t_phase                     r_phase, n_phase;
    logic [3:0]                 r_hcnt, n_hcnt;
    logic [7:0]                 r_major, n_major;
    logic                       r_ext_flag, n_ext_flag;
    logic [TAG_LENGTH_BITS-1:0] r_tag_len, n_tag_len;
    logic [TAG_LENGTH_BITS-1:0] r_frame_off, n_frame_off;
    logic [31:0]                r_frame_id, n_frame_id;
    logic [23:0]                r_pay_left, n_pay_left;
    logic [31:0]                r_acc, n_acc;
    logic [2:0]                 r_cur_field, n_cur_field;
    logic                       r_tf_sel, n_tf_sel;
    logic                       r_tf_nul, n_tf_nul;
    logic                       r_tf_end, n_tf_end;

    // Helper values
    logic            w_wide;
    logic [31:0]     w_hdr_acc;
    logic [31:0]     w_ext_acc;
    logic [31:0]     w_fh_id;
    logic [23:0]     w_fh_pl;
    logic            w_fh_last;
    logic [CmpW-1:0] w_fh_end_sum;
    logic [CmpW-1:0] w_fh_next;
    logic            w_fh_over;
    t_frame_hit      w_hit;
    logic            w_text_v, w_end_v, w_fin_v, w_walk;
    logic [1:0]      w_fin_st;

    assign w_go = r_in_valid && !i_full;
    assign o_in_ready = !r_in_valid || w_go;

    // Hold the byte until the queue can take its results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (w_go) begin
            r_in_valid <= 1'b0;
        end
        if (i_in_valid && o_in_ready) begin
            r_in_byte <= i_in_byte;
            r_in_last <= i_in_last;
        end
    end

    assign w_wide = r_ext_flag || (r_major != Ver2);
    assign w_hdr_acc = {r_acc[24:0], r_in_byte[6:0]};
    assign w_ext_acc = {r_acc[23:0], r_in_byte};
    assign w_hit = frame_lookup(r_frame_id, w_wide);

    // Assemble frame ID and size from the frame header bytes
    always_comb begin
        logic [31:0] base_id;
        logic [23:0] base_pl;
        base_id = (r_hcnt == 4'd0) ? 32'd0 : r_frame_id;
        base_pl = (r_hcnt == 4'd0) ? 24'd0 : r_pay_left;
        w_fh_id = base_id;
        w_fh_pl = base_pl;
        if (w_wide) begin
            if (r_hcnt < 4'd4) begin
                w_fh_id = {base_id[23:0], r_in_byte};
            end else if (r_hcnt == 4'd6 || r_hcnt == 4'd7) begin
                w_fh_pl = {base_pl[15:0], r_in_byte};
            end
        end else begin
            if (r_hcnt < 4'd3) begin
                w_fh_id = {base_id[23:0], r_in_byte};
            end else begin
                w_fh_pl = {base_pl[16:0], r_in_byte[6:0]};
            end
        end
        w_fh_last = (r_hcnt == (w_wide ? FhdrWideLast : FhdrNarrowLast));
    end

    // Frame bounds check and next frame offset
    assign w_fh_end_sum = CmpW'(r_frame_off) + CmpW'(w_fh_pl);
    assign w_fh_over = (w_fh_pl == 24'd0) || (w_fh_end_sum > CmpW'(r_tag_len));
    assign w_fh_next = w_fh_end_sum + (w_wide ? FhdrWideLen : FhdrNarrowLen);

    // Advance the walk by one byte and collect its results
    always_comb begin
        n_phase     = r_phase;
        n_hcnt      = r_hcnt;
        n_major     = r_major;
        n_ext_flag  = r_ext_flag;
        n_tag_len   = r_tag_len;
        n_frame_off = r_frame_off;
        n_frame_id  = r_frame_id;
        n_pay_left  = r_pay_left;
        n_acc       = r_acc;
        n_cur_field = r_cur_field;
        n_tf_sel    = r_tf_sel;
        n_tf_nul    = r_tf_nul;
        n_tf_end    = r_tf_end;
        w_text_v    = 1'b0;
        w_end_v     = 1'b0;
        w_fin_v     = 1'b0;
        w_fin_st    = ST_OK;
        w_walk      = 1'b0;

        unique case (r_phase)
            PH_HDR: begin
                if (r_hcnt < 4'd3 && r_in_byte != Sig[r_hcnt[1:0]]) begin
                    w_fin_v  = 1'b1;
                    w_fin_st = ST_NO_TAG;
                    n_phase  = PH_DONE;
                end else begin
                    if (r_hcnt == 4'd3) begin
                        n_major = r_in_byte;
                    end
                    if (r_hcnt == 4'd5) begin
                        n_ext_flag = r_in_byte[6];
                    end
                    if (r_hcnt >= 4'd6) begin
                        n_acc = w_hdr_acc;
                    end
                    if (r_hcnt >= HdrLast) begin
                        // Clamp the syncsafe length to the counter range
                        if ({2'b00, w_hdr_acc} > TagMax) begin
                            n_tag_len = TagMax[TAG_LENGTH_BITS-1:0];
                        end else begin
                            n_tag_len = w_hdr_acc[TAG_LENGTH_BITS-1:0];
                        end
                        n_hcnt      = 4'd0;
                        n_acc       = 32'd0;
                        n_pay_left  = 24'd0;
                        n_frame_off = '0;
                        if (r_ext_flag) begin
                            n_phase = PH_EXT;
                        end else if (r_major == Ver2 || r_major == Ver3) begin
                            w_walk = 1'b1;
                        end else begin
                            w_fin_v  = 1'b1;
                            w_fin_st = ST_NO_TAG;
                            n_phase  = PH_DONE;
                        end
                    end else begin
                        n_hcnt = r_hcnt + 4'd1;
                    end
                end
            end
            PH_EXT: begin
                if (r_hcnt == 4'd3) begin
                    n_pay_left = (r_in_byte == ExtCrcMark) ? 24'd1 : 24'd0;
                end else if (r_hcnt == 4'd4) begin
                    n_pay_left = (r_pay_left != 24'd0 && r_in_byte != 8'd0) ?
                                 ExtLongLen : ExtShortLen;
                end else if (r_hcnt >= 4'd6 && r_hcnt <= 4'd9) begin
                    n_acc = w_ext_acc;
                end
                // Take the padding size off the tag length, floor at zero
                if (r_hcnt == 4'd9) begin
                    if (CmpW'(r_tag_len) > CmpW'(w_ext_acc)) begin
                        n_tag_len = r_tag_len - w_ext_acc[TAG_LENGTH_BITS-1:0];
                    end else begin
                        n_tag_len = '0;
                    end
                end
                if (r_hcnt >= 4'd9 && (24'(r_hcnt) + 24'd1) >= n_pay_left) begin
                    n_frame_off = TAG_LENGTH_BITS'(n_pay_left);
                    n_pay_left  = 24'd0;
                    n_acc       = 32'd0;
                    w_walk      = 1'b1;
                end else begin
                    n_hcnt = r_hcnt + 4'd1;
                end
            end
            PH_FHDR: begin
                n_frame_id = w_fh_id;
                n_pay_left = w_fh_pl;
                if (!w_fh_last) begin
                    n_hcnt = r_hcnt + 4'd1;
                end else begin
                    n_hcnt = 4'd0;
                    if (w_fh_over) begin
                        w_fin_v = 1'b1;
                        n_phase = PH_DONE;
                    end else begin
                        n_tf_sel    = w_hit.hit;
                        n_tf_nul    = 1'b0;
                        n_tf_end    = 1'b0;
                        n_cur_field = w_hit.hit ? w_hit.fld : FLD_TITLE;
                        if (w_fh_next > TagMax) begin
                            n_frame_off = TagMax[TAG_LENGTH_BITS-1:0];
                        end else begin
                            n_frame_off = w_fh_next[TAG_LENGTH_BITS-1:0];
                        end
                        n_phase = PH_PAY;
                    end
                end
            end
            PH_PAY: begin
                // Skip the encoding byte up to the first NUL, emit up to the next
                if (r_tf_sel) begin
                    if (!r_tf_nul) begin
                        if (r_in_byte == 8'd0) begin
                            n_tf_nul = 1'b1;
                        end
                    end else if (!r_tf_end) begin
                        if (r_in_byte == 8'd0) begin
                            n_tf_end = 1'b1;
                        end else begin
                            w_text_v = 1'b1;
                        end
                    end
                end
                n_pay_left = r_pay_left - 24'd1;
                if (n_pay_left == 24'd0) begin
                    w_end_v  = r_tf_sel;
                    n_tf_sel = 1'b0;
                    n_tf_nul = 1'b0;
                    n_tf_end = 1'b0;
                    w_walk   = 1'b1;
                end
            end
            PH_DONE: begin
            end
            default: begin
            end
        endcase

        // Start the next frame or close the tag at its end
        if (w_walk) begin
            n_hcnt = 4'd0;
            if (n_frame_off >= n_tag_len) begin
                w_fin_v = 1'b1;
                n_phase = PH_DONE;
            end else begin
                n_phase = PH_FHDR;
            end
        end

        // End of file: report truncation if the tag is still open, and return to reset
        if (r_in_last) begin
            if (n_phase != PH_DONE) begin
                w_fin_v  = 1'b1;
                w_fin_st = ST_TRUNC;
            end
            n_phase     = PH_HDR;
            n_hcnt      = 4'd0;
            n_major     = 8'd0;
            n_ext_flag  = 1'b0;
            n_tag_len   = '0;
            n_frame_off = '0;
            n_frame_id  = 32'd0;
            n_pay_left  = 24'd0;
            n_acc       = 32'd0;
            n_cur_field = FLD_TITLE;
            n_tf_sel    = 1'b0;
            n_tf_nul    = 1'b0;
            n_tf_end    = 1'b0;
        end
    end

    // Results of this byte
    always_comb begin
        o_bundle                = '0;
        o_bundle.mask[SLOT_TEXT] = w_text_v;
        o_bundle.mask[SLOT_END]  = w_end_v;
        o_bundle.mask[SLOT_FIN]  = w_fin_v;
        o_bundle.field          = r_cur_field;
        o_bundle.text_byte      = r_in_byte;
        o_bundle.status         = w_fin_st;
    end

    assign o_push = w_go && (o_bundle.mask != '0);

    // Walk state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HDR;
            r_hcnt      <= 4'd0;
            r_major     <= 8'd0;
            r_ext_flag  <= 1'b0;
            r_tag_len   <= '0;
            r_frame_off <= '0;
            r_frame_id  <= 32'd0;
            r_pay_left  <= 24'd0;
            r_acc       <= 32'd0;
            r_cur_field <= FLD_TITLE;
            r_tf_sel    <= 1'b0;
            r_tf_nul    <= 1'b0;
            r_tf_end    <= 1'b0;
        end else if (w_go) begin
            r_phase     <= n_phase;
            r_hcnt      <= n_hcnt;
            r_major     <= n_major;
            r_ext_flag  <= n_ext_flag;
            r_tag_len   <= n_tag_len;
            r_frame_off <= n_frame_off;
            r_frame_id  <= n_frame_id;
            r_pay_left  <= n_pay_left;
            r_acc       <= n_acc;
            r_cur_field <= n_cur_field;
            r_tf_sel    <= n_tf_sel;
            r_tf_nul    <= n_tf_nul;
            r_tf_end    <= n_tf_end;
        end
    end

endmodule

`default_nettype wire

FILE: sv/id3tp_outq.sv
// Result queue of the ID3v2 text frame parser: holds result bundles and hands
// them out one result per request. Depends on id3tp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module id3tp_outq (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire id3tp_pkg::t_bundle i_bundle,
    output logic                    o_full,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic [1:0]              o_event,
    output logic [2:0]              o_field,
    output logic [7:0]              o_text,
    output logic [1:0]              o_status
);
    import id3tp_pkg::*;

    localparam int Depth = 4;
    localparam int PtrW = $clog2(Depth);

    t_bundle                r_mem [Depth];
    logic [PtrW-1:0]        r_wptr;
    logic [PtrW-1:0]        r_rptr;
    logic [PtrW:0]          r_count;
    logic [NUM_SLOTS-1:0]   r_sent;

    t_bundle                w_head;
    logic [NUM_SLOTS-1:0]   w_rem;
    logic [NUM_SLOTS-1:0]   w_pick;
    logic                   w_more;
    logic                   w_pop;
    logic                   w_retire;

    assign o_full  = (r_count == (PtrW+1)'(Depth));
    assign o_valid = (r_count != '0);
    assign w_head  = r_mem[r_rptr];
    assign w_rem   = w_head.mask & ~r_sent;

    // Pick the earliest result still pending in the head bundle
    always_comb begin
        w_pick   = '0;
        o_event  = EV_TAG;
        o_field  = FLD_TITLE;
        o_text   = 8'd0;
        o_status = w_head.status;
        if (w_rem[SLOT_TEXT]) begin
            w_pick[SLOT_TEXT] = 1'b1;
            o_event  = EV_TEXT;
            o_field  = w_head.field;
            o_text   = w_head.text_byte;
            o_status = ST_OK;
        end else if (w_rem[SLOT_END]) begin
            w_pick[SLOT_END] = 1'b1;
            o_event  = EV_END;
            o_field  = w_head.field;
            o_status = ST_OK;
        end else begin
            w_pick[SLOT_FIN] = 1'b1;
        end
    end

    assign w_more   = ((w_rem & ~w_pick) != '0);
    assign w_pop    = o_valid && i_ready;
    assign w_retire = w_pop && !w_more;

    // Store bundles
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_bundle;
        end
    end

    // Advance pointers and mark delivered results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
            r_sent  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (w_pop) begin
                if (w_more) begin
                    r_sent <= r_sent | w_pick;
                end else begin
                    r_sent <= '0;
                    r_rptr <= r_rptr + 1'b1;
                end
            end
            r_count <= r_count + (PtrW+1)'(i_push) - (PtrW+1)'(w_retire);
        end
    end

endmodule

`default_nettype wire
